@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms; each is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/alm_pkg.sv @@
// ----------------------------------------------------------------------------
// alm_pkg
// Widths, codes and the command and response types of the entry table.
// ----------------------------------------------------------------------------
package alm_pkg;

   localparam int ADDR_W = 64;
   localparam int SIZE_W = 64;
   localparam int POS_W  = 32;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_en;
      logic clr_all;
   } tbl_cmd_type;

   typedef struct packed {
      logic              valid;
      logic              live;
      logic [ADDR_W-1:0] address;
      logic [POS_W-1:0]  position;
   } tbl_rsp_type;

endpackage

@@ design/alm_req_if.sv @@
// ----------------------------------------------------------------------------
// alm_req_if
// Trace record channel: one word is one record or one finish request.
// ----------------------------------------------------------------------------
interface alm_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic        [63:0] address;
   logic signed [63:0] size;
   logic        [31:0] record_pos;

   modport source (output valid, output mode, output address, output size,
                   output record_pos, input ready);
   modport sink   (input valid, input mode, input address, input size,
                   input record_pos, output ready);
endinterface

@@ design/alm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// alm_rsp_if
// Leak report channel: one word is one reported leak or an empty report.
// ----------------------------------------------------------------------------
interface alm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] leak_pos;
   logic        leak_valid;
   logic        overflow;
   logic        last;

   modport source (output valid, output leak_pos, output leak_valid,
                   output overflow, output last, input ready);
   modport sink   (input valid, input leak_pos, input leak_valid,
                   input overflow, input last, output ready);
endinterface

@@ design/alm_table.sv @@
// ----------------------------------------------------------------------------
// alm_table
// Entry table: address and position memories with a registered read port,
// and a live bit per entry held in flip-flops.
// ----------------------------------------------------------------------------
module alm_table
   import alm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_cmd_type       cmd,
   input  logic [IDX_W-1:0]  rd_idx,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [ADDR_W-1:0] wr_address,
   input  logic [POS_W-1:0]  wr_position,
   output tbl_rsp_type       rsp,
   output logic [IDX_W-1:0]  rsp_idx,
   output logic              live_any
);

   logic [ADDR_W-1:0]        addr_mem [TABLE_ENTRIES];
   logic [POS_W-1:0]         pos_mem  [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] live_ff;
   logic [TABLE_ENTRIES-1:0] live_in;
   logic                     rd_valid_ff;
   logic                     rd_live_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic [ADDR_W-1:0]        rd_addr_ff;
   logic [POS_W-1:0]         rd_pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         addr_mem[wr_idx] <= wr_address;
         pos_mem[wr_idx]  <= wr_position;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= addr_mem[rd_idx];
         rd_pos_ff  <= pos_mem[rd_idx];
         rd_live_ff <= live_ff[rd_idx];
         rd_idx_ff  <= rd_idx;
      end
   end

   always_comb begin
      live_in = live_ff;
      if (cmd.clr_all) begin
         live_in = '0;
      end else begin
         if (cmd.wr_en) begin
            live_in[wr_idx] = 1'b1;
         end
         if (cmd.clr_en) begin
            live_in[wr_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         live_ff     <= live_in;
         rd_valid_ff <= cmd.rd_en;
      end
   end

   assign rsp.valid    = rd_valid_ff;
   assign rsp.live     = rd_live_ff;
   assign rsp.address  = rd_addr_ff;
   assign rsp.position = rd_pos_ff;
   assign rsp_idx      = rd_idx_ff;
   assign live_any     = |live_ff;

endmodule

@@ design/allocation_leak_matcher_top.sv @@
// ----------------------------------------------------------------------------
// allocation_leak_matcher_top
// Tracks live allocations from a trace and reports the unfreed ones.
// ----------------------------------------------------------------------------
// A word on req_chan is either a trace record (mode 0) or a finish request
// (mode 1). A record with a positive size inserts its address and position
// into the table unless the address is already live or no entry is free;
// any other size frees the live entry with that address. A record produces
// no output word. A finish request sends one word on rsp_chan per distinct
// leaked position, in ascending order, the final one flagged by last, and
// then empties the table. With nothing leaked it sends one word with
// leak_valid low. A record reads every table entry once, one entry a cycle;
// a finish request scans the table once per distinct leaked position and
// once more. req_chan is ready only between items, so a new word is not
// taken until the current item is through. The result sits in an output
// register, but a stalled receiver holds up a finish request at its next
// report word, and with it req_chan. Reset empties the table and clears the
// sticky overflow flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module allocation_leak_matcher_top
   import alm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input logic      clock,
   input logic      reset,
   alm_req_if.sink  req_chan,
   alm_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_SCAN     = 2'd1;
   localparam logic [1:0] ST_REC_DONE = 2'd2;
   localparam logic [1:0] ST_FIN_DONE = 2'd3;

   logic [1:0]        state_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              issue_ff;
   logic              fin_ff;
   logic              ins_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [POS_W-1:0]  req_pos_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              found_ff;
   logic [POS_W-1:0]  best_ff;
   logic              have_pend_ff;
   logic [POS_W-1:0]  pend_ff;
   logic              overflow_ff;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_leak_ff;
   logic              rsp_ovf_ff;
   logic              rsp_last_ff;

   tbl_cmd_type       tbl_cmd;
   tbl_rsp_type       tbl_rsp;
   logic [IDX_W-1:0]  tbl_rsp_idx;
   logic [IDX_W-1:0]  wr_idx;
   logic              live_any;
   logic              req_take;
   logic              out_free;
   logic              scan_end;
   logic              rec_match;
   logic              rec_free;
   logic              fin_better;
   logic              do_insert;
   logic              do_free;
   logic              fin_pending;
   logic              fin_emit;
   logic              fin_end;
   logic              restart;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign scan_end       = tbl_rsp.valid && (tbl_rsp_idx == LAST_IDX);

   assign rec_match  = tbl_rsp.valid && tbl_rsp.live && !hit_ff &&
                       (tbl_rsp.address == req_addr_ff);
   assign rec_free   = tbl_rsp.valid && !tbl_rsp.live && !free_ff;
   assign fin_better = tbl_rsp.valid && tbl_rsp.live &&
                       (!have_pend_ff || (tbl_rsp.position > pend_ff)) &&
                       (!found_ff || (tbl_rsp.position < best_ff));

   assign do_insert   = (state_ff == ST_REC_DONE) && ins_ff && !hit_ff && free_ff;
   assign do_free     = (state_ff == ST_REC_DONE) && !ins_ff && hit_ff;
   assign fin_pending = (state_ff == ST_FIN_DONE) && found_ff && have_pend_ff;
   assign fin_emit    = fin_pending && out_free;
   assign fin_end     = (state_ff == ST_FIN_DONE) && !found_ff && out_free;
   assign restart     = (state_ff == ST_FIN_DONE) && found_ff && (!have_pend_ff || out_free);
   assign wr_idx      = do_insert ? free_idx_ff : hit_idx_ff;

   always_comb begin
      tbl_cmd.rd_en   = (state_ff == ST_SCAN) && issue_ff;
      tbl_cmd.wr_en   = do_insert;
      tbl_cmd.clr_en  = do_free;
      tbl_cmd.clr_all = fin_end;
   end

   alm_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (tbl_cmd),
      .rd_idx      (idx_ff),
      .wr_idx      (wr_idx),
      .wr_address  (req_addr_ff),
      .wr_position (req_pos_ff),
      .rsp         (tbl_rsp),
      .rsp_idx     (tbl_rsp_idx),
      .live_any    (live_any)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_addr_ff <= req_chan.address;
         req_pos_ff  <= req_chan.record_pos;
         fin_ff      <= (req_chan.mode == MODE_FINISH);
         ins_ff      <= !req_chan.size[SIZE_W-1] && (req_chan.size != '0);
      end
      if (rec_match) begin
         hit_idx_ff <= tbl_rsp_idx;
      end
      if (rec_free) begin
         free_idx_ff <= tbl_rsp_idx;
      end
      if (fin_better) begin
         best_ff <= tbl_rsp.position;
      end
      if (restart) begin
         pend_ff <= best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         found_ff     <= 1'b0;
         have_pend_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_SCAN;
                  idx_ff   <= '0;
                  issue_ff <= 1'b1;
                  hit_ff   <= 1'b0;
                  free_ff  <= 1'b0;
                  found_ff <= 1'b0;
                  have_pend_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (issue_ff) begin
                  if (idx_ff == LAST_IDX) begin
                     issue_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
               if (rec_match) begin
                  hit_ff <= 1'b1;
               end
               if (rec_free) begin
                  free_ff <= 1'b1;
               end
               if (fin_better) begin
                  found_ff <= 1'b1;
               end
               if (scan_end) begin
                  state_ff <= fin_ff ? ST_FIN_DONE : ST_REC_DONE;
               end
            end
            ST_REC_DONE: begin
               if (ins_ff && !hit_ff && !free_ff) begin
                  overflow_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_FIN_DONE: begin
               if (restart) begin
                  have_pend_ff <= 1'b1;
                  state_ff     <= ST_SCAN;
                  idx_ff       <= '0;
                  issue_ff     <= 1'b1;
                  found_ff     <= 1'b0;
               end else if (fin_end) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_emit || fin_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_emit || fin_end) begin
         rsp_pos_ff  <= have_pend_ff ? pend_ff : '0;
         rsp_leak_ff <= have_pend_ff;
         rsp_ovf_ff  <= overflow_ff;
         rsp_last_ff <= fin_end;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.leak_pos   = rsp_pos_ff;
   assign rsp_chan.leak_valid = rsp_leak_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;
   assign rsp_chan.last       = rsp_last_ff;

   `ASSERT_NEXT(a_overflow_sticky, overflow_ff, overflow_ff, "overflow flag dropped")
   `ASSERT_SAME(a_read_in_scan, tbl_rsp.valid, state_ff == ST_SCAN, "table read outside scan")
   `ASSERT_SAME(a_report_ascending, fin_pending, best_ff > pend_ff, "report out of order")
   `ASSERT_NEXT(a_finish_clears, fin_end, !live_any, "table not empty after report")

endmodule

@@ tb/sv/alm_leak_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_leak_checker
// Watches both channels of the leak matcher, keeps its own live allocation
// table and checks every leak report word in order against it.
// ----------------------------------------------------------------------------
module alm_leak_checker
   import alm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   alm_req_if          req_mon,
   alm_rsp_if          rsp_mon,
   output int unsigned error_count,
   output int unsigned words_pending
);

   typedef struct packed {
      logic [POS_W-1:0] leak_pos;
      logic             leak_valid;
      logic             overflow;
      logic             last;
   } leak_word_type;

   logic [ADDR_W-1:0] table_addr [TABLE_ENTRIES];
   logic [POS_W-1:0]  table_pos  [TABLE_ENTRIES];
   logic              table_live [TABLE_ENTRIES];
   logic              overflow_sticky;
   leak_word_type     leak_q [$];

   task automatic push_leak(input logic [POS_W-1:0] pos, input logic valid, input logic last);
      leak_word_type w;
      w.leak_pos   = pos;
      w.leak_valid = valid;
      w.overflow   = overflow_sticky;
      w.last       = last;
      leak_q.push_back(w);
   endtask

   task automatic track_record(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
                               input logic [POS_W-1:0] pos);
      int hit;
      int slot;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && table_live[i] && table_addr[i] == addr) hit = i;
         if (slot < 0 && !table_live[i]) slot = i;
      end
      if (!size[SIZE_W-1] && size != '0) begin
         if (hit < 0) begin
            if (slot < 0) begin
               overflow_sticky = 1'b1;
            end else begin
               table_live[slot] = 1'b1;
               table_addr[slot] = addr;
               table_pos[slot]  = pos;
            end
         end
      end else if (hit >= 0) begin
         table_live[hit] = 1'b0;
      end
   endtask

   // Distinct live positions come out in ascending order, then the table empties.
   task automatic report_leaks();
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] best;
      logic             have_prev;
      logic             found;
      int               count;
      leak_word_type    w;
      count     = 0;
      have_prev = 1'b0;
      prev      = '0;
      do begin
         found = 1'b0;
         best  = '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (table_live[i] && (!have_prev || table_pos[i] > prev) &&
                (!found || table_pos[i] < best)) begin
               best  = table_pos[i];
               found = 1'b1;
            end
         end
         if (found) begin
            push_leak(best, 1'b1, 1'b0);
            prev      = best;
            have_prev = 1'b1;
            count++;
         end
      end while (found);
      if (count == 0) begin
         push_leak('0, 1'b0, 1'b1);
      end else begin
         w      = leak_q.pop_back();
         w.last = 1'b1;
         leak_q.push_back(w);
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) table_live[i] = 1'b0;
   endtask

   always @(posedge clock) begin
      leak_word_type got;
      leak_word_type want;
      int unsigned   errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) table_live[i] = 1'b0;
         overflow_sticky = 1'b0;
         leak_q.delete();
         error_count   <= 0;
         words_pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.leak_pos   = rsp_mon.leak_pos;
            got.leak_valid = rsp_mon.leak_valid;
            got.overflow   = rsp_mon.overflow;
            got.last       = rsp_mon.last;
            if (leak_q.size() == 0) begin
               $error("Unexpected report word: leak_pos %0d, leak_valid %0b, last %0b.",
                      got.leak_pos, got.leak_valid, got.last);
               errs++;
            end else begin
               want = leak_q.pop_front();
               if (got.leak_pos !== want.leak_pos) begin
                  $error("leak_pos: expected %0d, got %0d", want.leak_pos, got.leak_pos);
                  errs++;
               end
               if (got.leak_valid !== want.leak_valid) begin
                  $error("leak_valid: expected %0b, got %0b", want.leak_valid, got.leak_valid);
                  errs++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                  errs++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.mode == MODE_FINISH) begin
               report_leaks();
            end else begin
               track_record(req_mon.address, req_mon.size, req_mon.record_pos);
            end
         end
         error_count   <= error_count + errs;
         words_pending <= leak_q.size();
      end
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocation traces and finish requests into the leak matcher.
// A directed trace covers duplicate inserts, unknown frees, shared and
// unordered positions and empty reports; random traces with idle and stall
// phases, a long receiver hold and a table overflow follow.
// ----------------------------------------------------------------------------
module tb;
   import alm_pkg::*;

   localparam int TABLE_ENTRIES    = 64;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 4 * (TABLE_ENTRIES + 2);

   logic        clock;
   logic        reset;
   int unsigned error_count;
   int unsigned words_pending;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests  = 0;
   logic [31:0] trace_pos      = '0;

   alm_req_if req_chan ();
   alm_rsp_if rsp_chan ();

   allocation_leak_matcher_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   alm_leak_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .error_count  (error_count),
      .words_pending(words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // The receiver stalls at random, and holds off for a long stretch on request.
   initial begin
      int unsigned holds_served;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] alloc_size();
      logic [SIZE_W-1:0] s;
      case ($urandom_range(3))
         0:       s = 64'd1;
         1:       s = {1'b0, {63{1'b1}}};
         2:       s = 64'($urandom_range(4096, 1));
         default: s = {1'b0, 31'($urandom), $urandom};
      endcase
      if (s == '0) s = 64'd1;
      return s;
   endfunction

   function automatic logic [SIZE_W-1:0] free_size();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, 63'd0};
         default: return {1'b1, 31'($urandom), $urandom};
      endcase
   endfunction

   task automatic send_word(input logic mode, input logic [ADDR_W-1:0] addr,
                            input logic [SIZE_W-1:0] size, input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.address    <= addr;
      req_chan.size       <= size;
      req_chan.record_pos <= pos;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Positions mostly climb, now and then repeat or jump anywhere.
   task automatic send_record(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) trace_pos = $urandom;
      else if (pick > 1) trace_pos = trace_pos + 1;
      send_word(MODE_RECORD, addr, size, trace_pos);
   endtask

   task automatic send_finish();
      send_word(MODE_FINISH, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [ADDR_W-1:0] pool [8];
      logic [ADDR_W-1:0] base;
      int unsigned       idle_by_phase  [4];
      int unsigned       stall_by_phase [4];
      int unsigned       n;
      int unsigned       k;
      int unsigned       pick;

      idle_by_phase  = '{0, 75, 0, 25};
      stall_by_phase = '{0, 0, 75, 25};
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_RECORD;
      req_chan.address    <= '0;
      req_chan.size       <= '0;
      req_chan.record_pos <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(MODE_FINISH, '0, '0, '0);
      send_word(MODE_RECORD, '0, 64'd1, 32'd0);
      send_word(MODE_RECORD, '1, {1'b0, {63{1'b1}}}, '1);
      send_word(MODE_RECORD, '0, 64'd10, 32'd3);
      send_word(MODE_RECORD, 64'h0123_4567_89AB_CDEF, '0, 32'd4);
      send_word(MODE_RECORD, 64'hA5A5_A5A5_A5A5_A5A5, 64'd100, 32'd7);
      send_word(MODE_RECORD, 64'h5A5A_5A5A_5A5A_5A5A, 64'd3, 32'd7);
      send_word(MODE_RECORD, '1, {1'b1, 63'd0}, 32'd8);
      send_word(MODE_RECORD, 64'h0000_1000_0000_0040, 64'd9, 32'd2);
      send_word(MODE_RECORD, 64'h0000_1000_0000_0040, '1, 32'd9);
      send_word(MODE_FINISH, '1, '1, '1);
      send_word(MODE_RECORD, '0, '0, 32'd10);
      send_word(MODE_RECORD, 64'h5A5A_5A5A_5A5A_5A5A, 64'd1, 32'd11);
      send_word(MODE_FINISH, '0, '0, '0);
      trace_pos = 32'd12;
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_by_phase[phase];
         recv_stall_pct = stall_by_phase[phase];
         if (phase == 0) begin
            // A long report under a held receiver backs up into the record channel.
            for (int i = 0; i < 10; i++) send_record(pick_address(), alloc_size());
            hold_requests++;
            send_finish();
            repeat (6) send_record(pick_address(), alloc_size());
            send_finish();
            wait_drained();
         end
         if (phase == 2) begin
            // Fill the table past its size, so the overflow flag sets and stays set.
            base = {$urandom, $urandom};
            for (int i = 0; i < TABLE_ENTRIES + 2; i++) send_record(base + i, alloc_size());
            send_record(base, alloc_size());
            send_finish();
            send_finish();
         end
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 8; i++) pool[i] = pick_address();
            n = $urandom_range(8, 3);
            repeat (n) begin
               k    = $urandom_range(7);
               pick = $urandom_range(9);
               if (pick < 5) send_record(pool[k], alloc_size());
               else if (pick < 8) send_record(pool[k], free_size());
               else if (pick == 8) send_record(pick_address(), free_size());
               else send_record(pick_address(), alloc_size());
            end
            send_finish();
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && words_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
